>>> src/rhh_pkg.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Shared codes, controller states and the command/status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package rhh_pkg;

  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_ERASE = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [2:0] RES_INSERTED  = 3'd0;
  localparam logic [2:0] RES_UPDATED   = 3'd1;
  localparam logic [2:0] RES_FOUND     = 3'd2;
  localparam logic [2:0] RES_NOT_FOUND = 3'd3;
  localparam logic [2:0] RES_ERASED    = 3'd4;
  localparam logic [2:0] RES_CLEARED   = 3'd5;
  localparam logic [2:0] RES_OVERFLOW  = 3'd6;
  localparam logic [2:0] RES_FULL      = 3'd7;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HOME,
    ST_LOOK,
    ST_OVF,
    ST_INS,
    ST_CLR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       start;
    logic       seek;
    logic       advance;
    logic       wr_value;
    logic       wr_erase;
    logic       wr_carried;
    logic       swap;
    logic       clr_wr;
    logic       dist_step;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       res_load;
    logic       take_value;
    logic [2:0] res_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic home_ready;
    logic hit;
    logic empty;
    logic last_probe;
    logic full;
    logic ovf;
    logic occ;
    logic displace;
    logic cnt_zero;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

>>> src/rhh_home.sv
// ----------------------------------------------------------------------------
// Home slot unit
// Reduces the 32-bit hash modulo the table depth, four hash bits a cycle.
// ----------------------------------------------------------------------------
module rhh_home #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    hash,
  output logic [$clog2(TABLE_DEPTH)-1:0] home,
  output logic                           ready
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic [31:0]   sh;
  logic [2:0]    cnt;
  logic          busy;
  logic [IW-1:0] rem_next;

  // Restoring reduction: shift in one bit, subtract the depth if it fits.
  always_comb begin
    logic [IW:0] t;
    t = {1'b0, home};
    for (int k = 0; k < 4; k++) begin
      t = {t[IW-1:0], sh[31-k]};
      if (t >= (IW+1)'(TABLE_DEPTH)) begin
        t = t - (IW+1)'(TABLE_DEPTH);
      end
    end
    rem_next = t[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 3'd0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= hash;
      home <= '0;
    end else if (busy) begin
      sh   <= {sh[27:0], 4'h0};
      home <= rem_next;
    end
  end

  assign ready = !busy;

endmodule

>>> src/rhh_dp.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table datapath
// Slot memories, probe index, carried entry, occupancy count and the
// result and output registers.
// ----------------------------------------------------------------------------
module rhh_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 64,
  parameter int MAX_PROBE   = 63
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rhh_pkg::cmd_t                    cmd,
  output rhh_pkg::sts_t                    sts,
  input  logic [63:0]                      key_bytes,
  input  logic [3:0]                       key_length,
  input  logic [31:0]                      key_hash,
  input  logic [63:0]                      new_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [2:0]                       status,
  output logic [63:0]                      read_value,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

  localparam int IW       = $clog2(TABLE_DEPTH);
  localparam int CW       = $clog2(TABLE_DEPTH+1);
  localparam int FULL_LIM = TABLE_DEPTH * 3;

  logic [7:0]            status_mem [TABLE_DEPTH];
  logic [63:0]           key_mem    [TABLE_DEPTH];
  logic [3:0]            len_mem    [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem    [TABLE_DEPTH];

  logic [7:0]            rd_st;
  logic [63:0]           rd_key;
  logic [3:0]            rd_len;
  logic [VALUE_BITS-1:0] rd_val;

  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_inc;
  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         home;
  logic [5:0]            probe;
  logic [6:0]            cdist;
  logic [CW-1:0]         cnt;
  logic [63:0]           ckey;
  logic [3:0]            clen;
  logic [VALUE_BITS-1:0] cval;
  logic [63:0]           key_m;
  logic [7:0]            wr_st;
  logic                  st_wen;
  logic [2:0]            res_code;
  logic [63:0]           res_value;
  logic                  occ;
  logic                  match;
  logic [5:0]            st_dist;

  rhh_home #(.TABLE_DEPTH(TABLE_DEPTH)) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .hash  (key_hash),
    .home  (home),
    .ready (sts.home_ready)
  );

  // Key bytes at or above the length are dropped before storing or comparing.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      key_m[8*b +: 8] = (key_length > 4'(b)) ? key_bytes[8*b +: 8] : 8'h00;
    end
  end

  assign idx_inc = (idx == IW'(TABLE_DEPTH-1)) ? '0 : idx + IW'(1);
  assign rd_addr = cmd.seek ? home : (cmd.advance ? idx_inc : idx);

  always_ff @(posedge clk) begin
    rd_st  <= status_mem[rd_addr];
    rd_key <= key_mem[rd_addr];
    rd_len <= len_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  always_comb begin
    priority if (cmd.wr_carried) begin
      wr_st = {cdist[5:0], 2'b01};
    end else if (cmd.wr_erase) begin
      wr_st = {rd_st[7:2], 2'b10};
    end else begin
      wr_st = 8'h00;
    end
  end

  assign st_wen = cmd.wr_carried | cmd.wr_erase | cmd.clr_wr;

  always_ff @(posedge clk) begin
    if (st_wen) begin
      status_mem[idx] <= wr_st;
    end
    if (cmd.wr_carried) begin
      key_mem[idx] <= ckey;
      len_mem[idx] <= clen;
    end
    if (cmd.wr_carried) begin
      val_mem[idx] <= cval;
    end else if (cmd.wr_value) begin
      val_mem[idx] <= cval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cnt <= '0;
    end else begin
      if (cmd.start) begin
        idx <= '0;
      end else if (cmd.seek) begin
        idx <= home;
      end else if (cmd.advance) begin
        idx <= idx_inc;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_dec && cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // Probe count and displacement of the carried entry.
  always_ff @(posedge clk) begin
    if (cmd.seek) begin
      probe <= 6'd0;
      cdist <= 7'd0;
    end else begin
      if (cmd.advance) begin
        probe <= probe + 6'd1;
      end
      if (cmd.dist_step) begin
        cdist <= sts.displace ? {1'b0, st_dist} + 7'd1 : cdist + 7'd1;
      end
    end
  end

  // The carried entry takes the displaced resident on a swap.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ckey <= key_m;
      clen <= key_length;
      cval <= new_value[VALUE_BITS-1:0];
    end else if (cmd.swap) begin
      ckey <= rd_key;
      clen <= rd_len;
      cval <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_code  <= cmd.res_code;
      res_value <= cmd.take_value ? 64'(rd_val) : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_code;
      read_value  <= res_value;
      entry_count <= cnt;
    end
  end

  assign occ     = rd_st[0];
  assign st_dist = rd_st[7:2];
  assign match   = occ && (rd_len == clen) && (rd_key == ckey);

  assign sts.hit        = match;
  assign sts.empty      = !rd_st[0] && !rd_st[1];
  assign sts.last_probe = (probe == 6'(MAX_PROBE));
  assign sts.full       = ({cnt, 2'b00} >= (CW+2)'(FULL_LIM));
  assign sts.ovf        = (cdist > 7'(MAX_PROBE));
  assign sts.occ        = occ;
  assign sts.displace   = (cdist > {1'b0, st_dist});
  assign sts.cnt_zero   = (cnt == '0);
  assign sts.idx_last   = (idx == IW'(TABLE_DEPTH-1));
  assign sts.out_free   = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {cnt, 2'b00} < (CW+2)'(FULL_LIM + 4))
    else $error("occupancy count passed the load limit");

  a_write_dist: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_carried |-> cdist <= 7'(MAX_PROBE))
    else $error("entry stored with a probe distance beyond the limit");

  a_erase_count: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> cnt != '0)
    else $error("erase hit with an empty count");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten while still held");

endmodule

>>> src/rhh_ctrl.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table controller
// Sequences the home reduction, lookup, overflow dry run, insert walk,
// clear sweep and result hand-off.
// ----------------------------------------------------------------------------
module rhh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    mode,
  input  rhh_pkg::sts_t sts,
  output rhh_pkg::cmd_t cmd
);

  rhh_pkg::state_t state;
  rhh_pkg::state_t state_next;
  logic [1:0]      op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhh_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rhh_pkg::ST_IDLE && in_valid) begin
      op <= mode;
    end
  end

  assign in_ready = (state == rhh_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      rhh_pkg::ST_INIT: begin
        if (sts.idx_last) state_next = rhh_pkg::ST_IDLE;
      end
      rhh_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (mode == rhh_pkg::MODE_CLEAR) ? rhh_pkg::ST_CLR : rhh_pkg::ST_HOME;
        end
      end
      rhh_pkg::ST_HOME: begin
        if (sts.home_ready) state_next = rhh_pkg::ST_LOOK;
      end
      rhh_pkg::ST_LOOK: begin
        if (sts.hit) begin
          state_next = rhh_pkg::ST_RESP;
        end else if (sts.empty || sts.last_probe) begin
          if (op == rhh_pkg::MODE_SET && !sts.full) begin
            state_next = rhh_pkg::ST_OVF;
          end else begin
            state_next = rhh_pkg::ST_RESP;
          end
        end
      end
      rhh_pkg::ST_OVF: begin
        if (sts.ovf) begin
          state_next = rhh_pkg::ST_RESP;
        end else if (!sts.occ) begin
          state_next = rhh_pkg::ST_INS;
        end
      end
      rhh_pkg::ST_INS: begin
        if (!sts.occ) state_next = rhh_pkg::ST_RESP;
      end
      rhh_pkg::ST_CLR: begin
        if (sts.cnt_zero || sts.idx_last) state_next = rhh_pkg::ST_RESP;
      end
      rhh_pkg::ST_RESP: begin
        if (sts.out_free) state_next = rhh_pkg::ST_IDLE;
      end
      default: state_next = rhh_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      rhh_pkg::ST_INIT: begin
        cmd.clr_wr  = 1'b1;
        cmd.advance = 1'b1;
      end
      rhh_pkg::ST_IDLE: begin
        cmd.start = in_valid;
      end
      rhh_pkg::ST_HOME: begin
        cmd.seek = sts.home_ready;
      end
      rhh_pkg::ST_LOOK: begin
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          priority if (op == rhh_pkg::MODE_SET) begin
            cmd.wr_value = 1'b1;
            cmd.res_code = rhh_pkg::RES_UPDATED;
          end else if (op == rhh_pkg::MODE_ERASE) begin
            cmd.wr_erase = 1'b1;
            cmd.cnt_dec  = 1'b1;
            cmd.res_code = rhh_pkg::RES_ERASED;
          end else begin
            cmd.take_value = 1'b1;
            cmd.res_code   = rhh_pkg::RES_FOUND;
          end
        end else if (sts.empty || sts.last_probe) begin
          if (op == rhh_pkg::MODE_SET) begin
            if (sts.full) begin
              cmd.res_load = 1'b1;
              cmd.res_code = rhh_pkg::RES_FULL;
            end else begin
              cmd.seek = 1'b1;
            end
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = rhh_pkg::RES_NOT_FOUND;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      rhh_pkg::ST_OVF: begin
        if (sts.ovf) begin
          cmd.res_load = 1'b1;
          cmd.res_code = rhh_pkg::RES_OVERFLOW;
        end else if (!sts.occ) begin
          cmd.seek = 1'b1;
        end else begin
          cmd.dist_step = 1'b1;
          cmd.advance   = 1'b1;
        end
      end
      rhh_pkg::ST_INS: begin
        cmd.wr_carried = sts.occ ? sts.displace : 1'b1;
        if (sts.occ) begin
          cmd.swap      = sts.displace;
          cmd.dist_step = 1'b1;
          cmd.advance   = 1'b1;
        end else begin
          cmd.cnt_inc  = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = rhh_pkg::RES_INSERTED;
        end
      end
      rhh_pkg::ST_CLR: begin
        // An empty table keeps its tombstones through a clear.
        if (sts.cnt_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = rhh_pkg::RES_CLEARED;
        end else begin
          cmd.clr_wr  = 1'b1;
          cmd.advance = 1'b1;
          if (sts.idx_last) begin
            cmd.cnt_clr  = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_code = rhh_pkg::RES_CLEARED;
          end
        end
      end
      rhh_pkg::ST_RESP: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> src/robin_hood_hash_table.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Open-addressing table with linear probing, Robin Hood insertion and
// tombstone deletes; one result word for each request word.
// ----------------------------------------------------------------------------
// Sequence: the home-slot reduction runs first, then the lookup probes one slot
//   a cycle, then the result is presented. A set that inserts walks the
//   probe sequence twice more (overflow dry run, then insert), one slot a cycle.
// A clear of a non-empty table sweeps every slot of the status memory.
// One request is in flight at a time; the next word is taken only when idle.
// After reset a clearing pass over every slot runs before the first word.
module robin_hood_hash_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 64,
  parameter int MAX_PROBE   = 63
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       mode,
  input  logic [63:0]                      key_bytes,
  input  logic [3:0]                       key_length,
  input  logic [31:0]                      key_hash,
  input  logic [63:0]                      new_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       status,
  output logic [63:0]                      read_value,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

  rhh_pkg::cmd_t cmd;
  rhh_pkg::sts_t sts;

  rhh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  rhh_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .MAX_PROBE   (MAX_PROBE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .key_bytes   (key_bytes),
    .key_length  (key_length),
    .key_hash    (key_hash),
    .new_value   (new_value),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

endmodule
